[hw/rtl/sqdt_pkg.sv]
package sqdt_pkg;

  localparam int CAP_W  = 11;
  localparam int POS_W  = 11;
  localparam int ADDR_W = 18;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_FREE  = 3'd1;
  localparam logic [2:0] OP_PUT   = 3'd2;
  localparam logic [2:0] OP_GET   = 3'd3;
  localparam logic [2:0] OP_INFO  = 3'd4;

  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_DENIED  = 3'd1;
  localparam logic [2:0] STS_END     = 3'd2;
  localparam logic [2:0] STS_EMPTY   = 3'd3;
  localparam logic [2:0] STS_YOUNG   = 3'd4;
  localparam logic [2:0] STS_BAD_LEN = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DESC,
    ST_SLOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [5:0]         segment_index;
    logic signed [63:0] queue_id;
    logic [63:0]        queue_tag;
    logic [12:0]        data_length;
    logic signed [31:0] max_age_sec;
    logic [31:0]        now_sec;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [15:0]        slot_address;
    logic [12:0]        stored_length;
    logic [10:0]        fill_count;
    logic signed [63:0] owner_id;
    logic [63:0]        owner_tag;
  } rsp_t;

  typedef struct packed {
    logic [63:0]      owner_id;
    logic [63:0]      owner_tag;
    logic [POS_W-1:0] wr_pos;
    logic [POS_W-1:0] rd_pos;
  } desc_t;

  localparam desc_t DESC_RESET = '{
    owner_id:  64'hFFFF_FFFF_FFFF_FFFF,
    owner_tag: 64'd0,
    wr_pos:    11'd0,
    rd_pos:    11'd0
  };

  typedef struct packed {
    logic load;
    logic eval;
    logic slot_go;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_slot;
    logic out_free;
  } dp_stat_t;

endpackage

[hw/rtl/sqdt_req_if.sv]
interface sqdt_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [5:0]         segment_index;
  logic signed [63:0] queue_id;
  logic [63:0]        queue_tag;
  logic [12:0]        data_length;
  logic signed [31:0] max_age_sec;
  logic [31:0]        now_sec;

  modport source (
    output valid, func, segment_index, queue_id, queue_tag, data_length, max_age_sec,
           now_sec,
    input  ready
  );

  modport sink (
    input  valid, func, segment_index, queue_id, queue_tag, data_length, max_age_sec,
           now_sec,
    output ready
  );
endinterface

[hw/rtl/sqdt_rsp_if.sv]
interface sqdt_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [15:0]        slot_address;
  logic [12:0]        stored_length;
  logic [10:0]        fill_count;
  logic signed [63:0] owner_id;
  logic [63:0]        owner_tag;

  modport source (
    output valid, status, slot_address, stored_length, fill_count, owner_id, owner_tag,
    input  ready
  );

  modport sink (
    input  valid, status, slot_address, stored_length, fill_count, owner_id, owner_tag,
    output ready
  );
endinterface

[hw/rtl/sqdt_ctrl.sv]
module sqdt_ctrl
  import sqdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DESC;
      end
      ST_DESC: begin
        state_nxt = stat.need_slot ? ST_SLOT : ST_DONE;
      end
      ST_SLOT: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    cmd.load    = (state_r == ST_IDLE) && in_valid;
    cmd.eval    = (state_r == ST_DESC);
    cmd.slot_go = (state_r == ST_SLOT);
    cmd.finish  = (state_r == ST_DONE) && stat.out_free;
  end

endmodule

[hw/rtl/sqdt_dpath.sv]
module sqdt_dpath
  import sqdt_pkg::*;
#(
  parameter int SEGMENTS          = 64,
  parameter int SLOTS_PER_SEGMENT = 1024,
  parameter int MAX_DATA_BYTES    = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  req_t             in_req,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  ctrl_cmd_t        cmd,
  output dp_stat_t         stat,
  input  logic             out_ready,
  output logic             out_valid,
  output rsp_t             out_rsp
);

  localparam int SEG_AW     = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int SLOT_TOTAL = SEGMENTS * SLOTS_PER_SEGMENT;
  localparam int SLOT_AW    = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;

  // configuration
  logic [CAP_W-1:0] cap_r;
  logic [CAP_W-1:0] cap_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign cap_eff = (32'(cap_r) > SLOTS_PER_SEGMENT) ? CAP_W'(SLOTS_PER_SEGMENT) : cap_r;

  // request capture and descriptor read
  req_t              req_r;
  desc_t             desc_mem [SEGMENTS];
  logic [SEGMENTS-1:0] desc_valid_r;
  desc_t             desc_rd_r;
  logic              desc_hit_r;
  logic [SEG_AW-1:0] seg_in;
  logic [SEG_AW-1:0] seg_r;

  assign seg_in = SEG_AW'(in_req.segment_index);
  assign seg_r  = SEG_AW'(req_r.segment_index);

  // decision registers
  logic [2:0]        status_r;
  logic [ADDR_W-1:0] addr_r;
  logic [POS_W-1:0]  fill_r;
  logic [63:0]       oid_r;
  logic [63:0]       otag_r;
  desc_t             new_desc_r;
  logic              desc_we_r;
  logic              put_r;
  logic              get_r;

  // finishing values
  logic              fin_we;
  logic [2:0]        fin_status;
  logic [12:0]       fin_slen;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r      <= in_req;
      desc_rd_r  <= desc_mem[seg_in];
      desc_hit_r <= desc_valid_r[seg_in];
    end
    if (cmd.finish && fin_we) begin
      desc_mem[seg_r] <= new_desc_r;
    end
  end

  // unwritten descriptors read as their reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_valid_r <= '0;
    end else if (cmd.finish && fin_we) begin
      desc_valid_r[seg_r] <= 1'b1;
    end
  end

  // evaluation of the descriptor
  desc_t             cur;
  logic              seg_ok;
  logic              owner_ok;
  logic              positive;
  logic [ADDR_W-1:0] base;
  logic [2:0]        e_status;
  logic [ADDR_W-1:0] e_addr;
  logic [POS_W-1:0]  e_fill;
  logic [63:0]       e_oid;
  logic [63:0]       e_otag;
  desc_t             e_desc;
  logic              e_we;
  logic              e_put;
  logic              e_get;

  assign cur      = desc_hit_r ? desc_rd_r : DESC_RESET;
  assign seg_ok   = 32'(req_r.segment_index) < SEGMENTS;
  assign owner_ok = (cur.owner_id == req_r.queue_id) && (cur.owner_tag == req_r.queue_tag);
  assign positive = (cur.owner_id != 64'd0) && !cur.owner_id[63];
  assign base     = ADDR_W'(req_r.segment_index) * ADDR_W'(cap_eff);

  always_comb begin
    e_status = STS_DENIED;
    e_addr   = '0;
    e_fill   = '0;
    e_oid    = '0;
    e_otag   = '0;
    e_desc   = cur;
    e_we     = 1'b0;
    e_put    = 1'b0;
    e_get    = 1'b0;
    if (seg_ok) begin
      unique case (req_r.func)
        OP_ALLOC: begin
          if (!positive) begin
            e_desc           = DESC_RESET;
            e_desc.owner_id  = req_r.queue_id;
            e_desc.owner_tag = req_r.queue_tag;
            e_we             = 1'b1;
            e_status         = STS_OK;
          end
        end
        OP_FREE: begin
          if (!(cur.rd_pos < cur.wr_pos)) begin
            e_desc   = DESC_RESET;
            e_we     = 1'b1;
            e_status = STS_OK;
          end
        end
        OP_PUT: begin
          priority if (!owner_ok) begin
            e_status = STS_DENIED;
          end else if (cur.wr_pos >= cap_eff) begin
            e_status = STS_END;
          end else begin
            e_addr        = base + ADDR_W'(cur.wr_pos);
            e_desc.wr_pos = cur.wr_pos + POS_W'(1);
            e_we          = 1'b1;
            e_put         = 1'b1;
            e_status      = STS_OK;
          end
        end
        OP_GET: begin
          priority if (!owner_ok) begin
            e_status = STS_DENIED;
          end else if (cur.rd_pos >= cap_eff) begin
            e_status = STS_END;
          end else if (cur.rd_pos >= cur.wr_pos) begin
            e_status = STS_EMPTY;
          end else begin
            // final status and write-back are settled once the slot is read
            e_addr        = base + ADDR_W'(cur.rd_pos);
            e_desc.rd_pos = cur.rd_pos + POS_W'(1);
            e_get         = 1'b1;
            e_status      = STS_OK;
          end
        end
        OP_INFO: begin
          e_fill   = cur.wr_pos - cur.rd_pos;
          e_oid    = cur.owner_id;
          e_otag   = cur.owner_tag;
          e_status = STS_OK;
        end
        default: e_status = STS_DENIED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      status_r   <= e_status;
      addr_r     <= e_addr;
      fill_r     <= e_fill;
      oid_r      <= e_oid;
      otag_r     <= e_otag;
      new_desc_r <= e_desc;
      desc_we_r  <= e_we;
      put_r      <= e_put;
      get_r      <= e_get;
    end
  end

  assign stat.need_slot = e_put || e_get;

  // slot storage
  logic [31:0]        slot_time_mem [SLOT_TOTAL];
  logic [12:0]        slot_len_mem  [SLOT_TOTAL];
  logic [31:0]        slot_ts_r;
  logic [12:0]        slot_len_r;
  logic [SLOT_AW-1:0] slot_idx;

  assign slot_idx = SLOT_AW'(addr_r);

  always_ff @(posedge clk) begin
    if (cmd.slot_go) begin
      if (put_r) begin
        slot_time_mem[slot_idx] <= req_r.now_sec;
        slot_len_mem[slot_idx]  <= req_r.data_length;
      end else begin
        slot_ts_r  <= slot_time_mem[slot_idx];
        slot_len_r <= slot_len_mem[slot_idx];
      end
    end
  end

  // age and length checks for get
  logic signed [33:0] age_limit;
  logic signed [33:0] ts_ext;
  logic               too_young;
  logic               len_bad;

  assign age_limit = $signed({2'b00, req_r.now_sec}) - 34'(req_r.max_age_sec);
  assign ts_ext    = $signed({2'b00, slot_ts_r});
  assign too_young = (req_r.max_age_sec > 0) && (ts_ext > age_limit);
  assign len_bad   = (slot_len_r == 13'd0) || (32'(slot_len_r) > MAX_DATA_BYTES);

  always_comb begin
    fin_we     = desc_we_r;
    fin_status = status_r;
    fin_slen   = '0;
    if (get_r) begin
      fin_slen = slot_len_r;
      priority if (too_young) begin
        fin_we     = 1'b0;
        fin_status = STS_YOUNG;
      end else if (len_bad) begin
        fin_we     = 1'b1;
        fin_status = STS_BAD_LEN;
      end else begin
        fin_we     = 1'b1;
        fin_status = STS_OK;
      end
    end
  end

  // output register
  logic out_valid_r;

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_rsp.status        <= fin_status;
      out_rsp.slot_address  <= 16'(addr_r);
      out_rsp.stored_length <= fin_slen;
      out_rsp.fill_count    <= fill_r;
      out_rsp.owner_id      <= oid_r;
      out_rsp.owner_tag     <= otag_r;
    end
  end

endmodule

[hw/rtl/segment_queue_descriptor_table.sv]
// sequence: an accepted beat is captured with its descriptor, which is then evaluated and
//   the decision registered; put and get that reach their slot then access the slot
//   memory (alloc, free, info and denied beats skip it); the result is registered and the
//   descriptor written back once the output register is free; one beat at a time
// reset: synchronous active-low; all segments read as unowned and empty, capacity 1024,
//   slot contents stay undefined until written
module segment_queue_descriptor_table
  import sqdt_pkg::*;
#(
  parameter int SEGMENTS          = 64,
  parameter int SLOTS_PER_SEGMENT = 1024,
  parameter int MAX_DATA_BYTES    = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  sqdt_req_if.sink         in_ch,
  sqdt_rsp_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  req_t      req;
  rsp_t      rsp;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;
  logic      out_valid;

  assign req.func          = in_ch.func;
  assign req.segment_index = in_ch.segment_index;
  assign req.queue_id      = in_ch.queue_id;
  assign req.queue_tag     = in_ch.queue_tag;
  assign req.data_length   = in_ch.data_length;
  assign req.max_age_sec   = in_ch.max_age_sec;
  assign req.now_sec       = in_ch.now_sec;
  assign in_ch.ready       = in_ready;

  assign out_ch.valid         = out_valid;
  assign out_ch.status        = rsp.status;
  assign out_ch.slot_address  = rsp.slot_address;
  assign out_ch.stored_length = rsp.stored_length;
  assign out_ch.fill_count    = rsp.fill_count;
  assign out_ch.owner_id      = rsp.owner_id;
  assign out_ch.owner_tag     = rsp.owner_tag;

  sqdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sqdt_dpath #(
    .SEGMENTS          (SEGMENTS),
    .SLOTS_PER_SEGMENT (SLOTS_PER_SEGMENT),
    .MAX_DATA_BYTES    (MAX_DATA_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_rsp   (rsp)
  );

  // one beat in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted on consecutive cycles");

  // only a slot access leaves an address behind
  a_addr_only_on_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != STS_OK && out_ch.status != STS_YOUNG &&
     out_ch.status != STS_BAD_LEN) |-> (out_ch.slot_address == 16'd0))
    else $error("slot address on a beat that touched no slot");

  // fill count comes from info, which always succeeds
  a_fill_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.fill_count != 11'd0) |-> (out_ch.status == STS_OK))
    else $error("fill count on a failed beat");

endmodule

[tb/sv/sqdt_table_monitor.sv]
module sqdt_table_monitor
  import sqdt_pkg::*;
#(
  parameter int SEGMENTS          = 64,
  parameter int SLOTS_PER_SEGMENT = 1024,
  parameter int MAX_DATA_BYTES    = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  sqdt_req_if              req_mon,
  sqdt_rsp_if              rsp_mon,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  output int unsigned      fail_count,
  output int unsigned      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_TOTAL = SEGMENTS * SLOTS_PER_SEGMENT;
  localparam int PRINT_CAP  = 100;

  // shadow of the descriptor table and slot memories
  logic [CAP_W-1:0] cap_reg;
  longint           own_id  [SEGMENTS];
  logic [63:0]      own_tag [SEGMENTS];
  logic [POS_W-1:0] wr_pos  [SEGMENTS];
  logic [POS_W-1:0] rd_pos  [SEGMENTS];
  logic [31:0]      stamp_mem [SLOT_TOTAL];
  logic [12:0]      len_mem   [SLOT_TOTAL];

  rsp_t awaited_rsp[$];

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (fail_count < PRINT_CAP)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void clear_segment(int unsigned s);
    own_id[s]  = -1;
    own_tag[s] = '0;
    wr_pos[s]  = '0;
    rd_pos[s]  = '0;
  endfunction

  function automatic rsp_t serve_request(req_t r);
    rsp_t        o;
    int unsigned seg;
    int unsigned cap;
    int unsigned wp;
    int unsigned rp;
    int unsigned slot;
    longint      age;
    longint      stamp;
    longint      now_l;
    logic        owner_ok;
    o = '0;
    o.status = STS_DENIED;
    seg = r.segment_index;
    cap = (cap_reg > SLOTS_PER_SEGMENT) ? SLOTS_PER_SEGMENT : cap_reg;
    if (seg >= SEGMENTS) return o;
    wp = wr_pos[seg];
    rp = rd_pos[seg];
    owner_ok = (own_id[seg] == r.queue_id) && (own_tag[seg] == r.queue_tag);
    case (r.func)
      OP_ALLOC: begin
        // only a positive owner id blocks a claim
        if (own_id[seg] <= 0) begin
          clear_segment(seg);
          own_id[seg]  = r.queue_id;
          own_tag[seg] = r.queue_tag;
          o.status = STS_OK;
        end
      end
      OP_FREE: begin
        if (rp >= wp) begin
          clear_segment(seg);
          o.status = STS_OK;
        end
      end
      OP_PUT: begin
        if (!owner_ok) o.status = STS_DENIED;
        else if (wp >= cap) o.status = STS_END;
        else begin
          slot = seg * cap + wp;
          stamp_mem[slot] = r.now_sec;
          len_mem[slot]   = r.data_length;
          wr_pos[seg] = POS_W'(wp + 1);
          o.slot_address = 16'(slot);
          o.status = STS_OK;
        end
      end
      OP_GET: begin
        if (!owner_ok) o.status = STS_DENIED;
        else if (rp >= cap) o.status = STS_END;
        else if (rp >= wp) o.status = STS_EMPTY;
        else begin
          slot = seg * cap + rp;
          o.slot_address  = 16'(slot);
          o.stored_length = len_mem[slot];
          age   = $signed(r.max_age_sec);
          stamp = {32'd0, stamp_mem[slot]};
          now_l = {32'd0, r.now_sec};
          if (age > 0 && stamp > now_l - age) o.status = STS_YOUNG;
          else begin
            rd_pos[seg] = POS_W'(rp + 1);
            if (len_mem[slot] == 0 || len_mem[slot] > MAX_DATA_BYTES) o.status = STS_BAD_LEN;
            else o.status = STS_OK;
          end
        end
      end
      OP_INFO: begin
        o.fill_count = 11'(wp - rp);
        o.owner_id   = own_id[seg];
        o.owner_tag  = own_tag[seg];
        o.status     = STS_OK;
      end
      default: o.status = STS_DENIED;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin : watch
    req_t beat;
    rsp_t seen;
    rsp_t want;
    if (!rst_n) begin
      cap_reg = CAP_RESET;
      for (int s = 0; s < SEGMENTS; s++) clear_segment(s);
      awaited_rsp.delete();
    end else begin
      // result side first: a result never belongs to a beat taken at the same edge
      if (rsp_mon.valid && rsp_mon.ready) begin
        seen.status        = rsp_mon.status;
        seen.slot_address  = rsp_mon.slot_address;
        seen.stored_length = rsp_mon.stored_length;
        seen.fill_count    = rsp_mon.fill_count;
        seen.owner_id      = rsp_mon.owner_id;
        seen.owner_tag     = rsp_mon.owner_tag;
        if (awaited_rsp.size() == 0) begin
          report_mismatch("result beat with nothing pending", 64'(seen.status), '0);
        end else begin
          want = awaited_rsp.pop_front();
          if (seen.status !== want.status)
            report_mismatch("status", 64'(seen.status), 64'(want.status));
          if (seen.slot_address !== want.slot_address)
            report_mismatch("slot_address", 64'(seen.slot_address), 64'(want.slot_address));
          if (seen.stored_length !== want.stored_length)
            report_mismatch("stored_length", 64'(seen.stored_length), 64'(want.stored_length));
          if (seen.fill_count !== want.fill_count)
            report_mismatch("fill_count", 64'(seen.fill_count), 64'(want.fill_count));
          if (seen.owner_id !== want.owner_id)
            report_mismatch("owner_id", seen.owner_id, want.owner_id);
          if (seen.owner_tag !== want.owner_tag)
            report_mismatch("owner_tag", seen.owner_tag, want.owner_tag);
        end
      end
      if (cfg_we) cap_reg = cfg_wdata;
      if (req_mon.valid && req_mon.ready) begin
        beat.func          = req_mon.func;
        beat.segment_index = req_mon.segment_index;
        beat.queue_id      = req_mon.queue_id;
        beat.queue_tag     = req_mon.queue_tag;
        beat.data_length   = req_mon.data_length;
        beat.max_age_sec   = req_mon.max_age_sec;
        beat.now_sec       = req_mon.now_sec;
        awaited_rsp.push_back(serve_request(beat));
      end
    end
    outstanding = awaited_rsp.size();
  end

endmodule

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sqdt_pkg::*;

  localparam int     NUM_SEG      = 64;
  localparam int     MAX_SLOTS    = 1024;
  localparam int     PHASES       = 7;
  localparam int     PHASE_BEATS  = 278;
  localparam int     CALM_BEATS   = 150;
  localparam int     RESYNC_EVERY = 64;
  localparam longint CYCLE_LIMIT  = 800000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic             rsp_ready = 1'b0;
  logic             tail_calm = 1'b0;
  int unsigned      ready_hold = 0;
  longint           cycle_cnt = 0;
  int unsigned      fail_count;
  int unsigned      outstanding;

  // what the stimulus believes about each segment
  logic        held     [NUM_SEG];
  longint      held_id  [NUM_SEG];
  logic [63:0] held_tag [NUM_SEG];
  int          held_fill[NUM_SEG];
  logic [5:0]  hot_seg  [4];
  int          cap_eff;
  logic [31:0] now_clk;

  sqdt_req_if req_if ();
  sqdt_rsp_if rsp_if ();

  assign rsp_if.ready = rsp_ready;

  segment_queue_descriptor_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_if),
    .out_ch    (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sqdt_table_monitor u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_if),
    .rsp_mon     (rsp_if),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: ready drops low in random bursts between high runs
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (tail_calm) begin
      rsp_ready <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      rsp_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 14);
    end else begin
      rsp_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 40);
    end
  end

  task automatic push_request(req_t r);
    req_if.valid         <= 1'b1;
    req_if.func          <= r.func;
    req_if.segment_index <= r.segment_index;
    req_if.queue_id      <= r.queue_id;
    req_if.queue_tag     <= r.queue_tag;
    req_if.data_length   <= r.data_length;
    req_if.max_age_sec   <= r.max_age_sec;
    req_if.now_sec       <= r.now_sec;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic issue(logic [2:0] f, int seg, logic [63:0] id, logic [63:0] tag,
                       int len, int age, logic [31:0] now);
    req_t r;
    r.func          = f;
    r.segment_index = 6'(seg);
    r.queue_id      = id;
    r.queue_tag     = tag;
    r.data_length   = 13'(len);
    r.max_age_sec   = age;
    r.now_sec       = now;
    push_request(r);
  endtask

  task automatic sender_gap(int n);
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // negedge sampling keeps the pending count clear of the edge updates
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic resync_owners();
    wait_drained();
    for (int s = 0; s < NUM_SEG; s++) begin
      held_id[s]   = u_chk.own_id[s];
      held_tag[s]  = u_chk.own_tag[s];
      held[s]      = !(held_id[s] == -1 && held_tag[s] == 0);
      held_fill[s] = int'(u_chk.wr_pos[s]) - int'(u_chk.rd_pos[s]);
    end
  endtask

  // empty every segment so that no slot is read under a different capacity
  task automatic drain_segments();
    for (int s = 0; s < NUM_SEG; s++)
      while (u_chk.rd_pos[s] < u_chk.wr_pos[s]) begin
        issue(OP_GET, s, u_chk.own_id[s], u_chk.own_tag[s], 0, 0, now_clk);
        wait_drained();
      end
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap_eff = (v > MAX_SLOTS) ? MAX_SLOTS : int'(v);
  endtask

  function automatic req_t compose_request();
    req_t       r;
    logic [5:0] s;
    int         pick;
    longint     id;
    now_clk = now_clk + $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) begin
      r.func          = 3'($urandom_range(0, 7));
      r.segment_index = 6'($urandom);
      r.queue_id      = {$urandom, $urandom};
      r.queue_tag     = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) begin
        r.queue_id  = -1;
        r.queue_tag = '0;
      end
      r.data_length = 13'($urandom);
      r.max_age_sec = $urandom;
      r.now_sec     = $urandom;
      return r;
    end
    s = ($urandom_range(0, 6) == 0) ? 6'($urandom) : hot_seg[$urandom_range(0, 3)];
    r.segment_index = s;
    r.queue_id      = held_id[s];
    r.queue_tag     = held_tag[s];
    r.now_sec       = now_clk;
    case ($urandom_range(0, 19))
      0:       r.data_length = '0;
      1:       r.data_length = 13'($urandom_range(4097, 8191));
      2:       r.data_length = 13'd4096;
      default: r.data_length = 13'($urandom_range(1, 4096));
    endcase
    if ($urandom_range(0, 2) == 0) r.max_age_sec = $urandom_range(1, 6);
    else r.max_age_sec = 32'd0 - 32'($urandom_range(0, 3));
    if (!held[s]) begin
      case ($urandom_range(0, 7))
        0:       id = 0;
        1:       id = -longint'($urandom_range(1, 100000));
        2:       id = {1'b0, 31'($urandom), $urandom};
        default: id = $urandom_range(1, 100000);
      endcase
      r.func      = OP_ALLOC;
      r.queue_id  = id;
      r.queue_tag = {$urandom, $urandom};
      held[s]      = 1'b1;
      held_id[s]   = id;
      held_tag[s]  = r.queue_tag;
      held_fill[s] = 0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
        r.func = OP_PUT;
        if (held_fill[s] < cap_eff) held_fill[s]++;
      end else if (pick < 80) begin
        r.func = OP_GET;
        if (r.max_age_sec <= 0 && held_fill[s] > 0) held_fill[s]--;
      end else if (pick < 88) begin
        r.func = OP_INFO;
      end else if (pick < 95) begin
        r.func = OP_FREE;
        if (held_fill[s] == 0) held[s] = 1'b0;
      end else if (pick < 97) begin
        r.func     = OP_ALLOC;
        r.queue_id = $urandom_range(1, 100000);
      end else begin
        // right id, one tag bit off
        r.func      = pick[0] ? OP_PUT : OP_GET;
        r.queue_tag = held_tag[s] ^ (64'd1 << $urandom_range(0, 63));
      end
    end
    return r;
  endfunction

  initial begin
    logic [CAP_W-1:0] cap_plan[PHASES];
    req_if.valid         = 1'b0;
    req_if.func          = OP_INFO;
    req_if.segment_index = '0;
    req_if.queue_id      = '0;
    req_if.queue_tag     = '0;
    req_if.data_length   = '0;
    req_if.max_age_sec   = '0;
    req_if.now_sec       = '0;
    cap_eff = MAX_SLOTS;
    now_clk = $urandom;
    cap_plan = '{CAP_RESET, 11'd1, 11'd0, 11'd2047, 11'd6, 11'd1024,
                 11'($urandom_range(2, 40))};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset owner is id -1 with tag 0, so a matching put goes through
    issue(OP_INFO, 0, '0, '0, 0, 0, 0);
    issue(OP_PUT, 0, -64'sd1, '0, 4096, 0, 32'hFFFF_FFFF);
    issue(OP_GET, 0, -64'sd1, '0, 0, 1, 32'hFFFF_FFFF);
    issue(OP_GET, 0, -64'sd1, '0, 0, 32'sh8000_0000, 32'hFFFF_FFFF);
    issue(OP_GET, 0, -64'sd1, '0, 0, 0, 32'hFFFF_FFFF);
    issue(OP_ALLOC, 63, 64'h7FFF_FFFF_FFFF_FFFF, '1, 0, 0, 0);
    issue(OP_ALLOC, 63, 64'd5, '1, 0, 0, 0);
    issue(OP_PUT, 63, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 1, 0, 0);
    issue(OP_PUT, 63, 64'h7FFF_FFFF_FFFF_FFFF, '1, 0, 0, 0);
    issue(OP_PUT, 63, 64'h7FFF_FFFF_FFFF_FFFF, '1, 8191, 0, 100);
    issue(OP_FREE, 63, '0, '0, 0, 0, 0);
    issue(OP_GET, 63, 64'h7FFF_FFFF_FFFF_FFFF, '1, 0, 32'sh7FFF_FFFF, 0);
    issue(OP_GET, 63, 64'h7FFF_FFFF_FFFF_FFFF, '1, 0, 0, 0);
    issue(OP_GET, 63, 64'h7FFF_FFFF_FFFF_FFFF, '1, 0, 1, 101);
    issue(OP_INFO, 63, '0, '0, 0, 0, 0);
    issue(OP_FREE, 63, 64'd3, 64'd3, 0, 0, 0);
    issue(OP_ALLOC, 1, 64'd7, 64'd7, 0, 0, 0);
    issue(3'd5, 1, 64'd7, 64'd7, 0, 0, 0);
    issue(3'd6, 1, 64'd7, 64'd7, 0, 0, 0);
    issue(3'd7, 1, 64'd7, 64'd7, 0, 0, 0);
    issue(OP_ALLOC, 5, -64'sd7, 64'd1, 0, 0, 0);
    issue(OP_ALLOC, 5, 64'd0, 64'd2, 0, 0, 0);
    issue(OP_ALLOC, 5, 64'd9, 64'd3, 0, 0, 0);
    issue(OP_INFO, 5, '0, '0, 0, 0, 0);
    issue(OP_FREE, 5, '0, '0, 0, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        drain_segments();
        write_capacity(cap_plan[p]);
      end
      resync_owners();
      for (int h = 0; h < 4; h++) hot_seg[h] = 6'($urandom);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (i % RESYNC_EVERY == RESYNC_EVERY - 1) resync_owners();
        if (p == PHASES - 1 && i == PHASE_BEATS - CALM_BEATS) tail_calm <= 1'b1;
        if (!tail_calm && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 15));
        push_request(compose_request());
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sqdt_pkg.sv
hw/rtl/sqdt_req_if.sv
hw/rtl/sqdt_rsp_if.sv
hw/rtl/sqdt_ctrl.sv
hw/rtl/sqdt_dpath.sv
hw/rtl/segment_queue_descriptor_table.sv
tb/sv/sqdt_table_monitor.sv
tb/sv/testbench.sv
